### sv/gaca_pkg.sv
// ============================================================================
// gaca_pkg: shared types and constants of the column annotator
// Result layout, controller commands and status, state codes, register
// indexes and the saturating position add.
// ============================================================================
package gaca_pkg;

   // longest pad run that is held back before it is released as overflow
   localparam logic [5:0] MaxGap = 6'd63;

   // position counters saturate at 2^PosBits - 1, capped at 16 bits
   localparam int PosBits = 16;
   localparam int PosCapBits = (PosBits > 16) ? 16 : PosBits;
   localparam logic [15:0] PosMax = 16'((32'd1 << PosCapBits) - 32'd1);

   localparam logic [7:0] PadSymbolAReset = 8'd42;
   localparam logic [7:0] PadSymbolBReset = 8'd45;

   typedef enum logic {
      CSR_PAD_A = 1'b0,
      CSR_PAD_B = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [15:0] padded_pos;
      logic [15:0] unpadded_pos;
      logic [15:0] pos_before;
      logic [16:0] pos_after;
      logic [7:0]  out_quality;
      logic        is_pad;
      logic [5:0]  gap_length;
      logic        gap_closed;
      logic        gap_overflow;
   } result_type;

   typedef struct packed {
      logic accept;     // take the input beat and update sequence state
      logic load_out;   // load one result beat into the output register
      logic use_saved;  // generate from the saved plan instead of the new one
      logic advance;    // step the saved plan's result index
   } cmd_type;

   typedef struct packed {
      logic out_free;         // output register empty or draining this cycle
      logic new_has_result;   // the offered beat causes at least one result
      logic new_more;         // the offered beat causes more than one result
      logic saved_last;       // saved plan's current result is its final one
   } status_type;

   function automatic logic [15:0] sat_add(logic [15:0] a, logic [6:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {10'd0, b};
      return (s > {1'b0, PosMax}) ? PosMax : s[15:0];
   endfunction

endpackage

### sv/gaca_if.sv
// ============================================================================
// gaca_if: channel interfaces of the column annotator
// Column input, result output and register write channels, each with a
// source and a sink modport.
// ============================================================================
interface gaca_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [7:0] base_quality;
   logic       seq_end;

   modport source(output valid, output symbol, output base_quality, output seq_end,
                  input ready);
   modport sink(input valid, input symbol, input base_quality, input seq_end,
                output ready);
endinterface

interface gaca_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] padded_pos;
   logic [15:0] unpadded_pos;
   logic [15:0] pos_before;
   logic [16:0] pos_after;
   logic [7:0]  out_quality;
   logic        is_pad;
   logic [5:0]  gap_length;
   logic        gap_closed;
   logic        gap_overflow;
   logic        last_of_run;
   logic        last_of_seq;

   modport source(output valid, output padded_pos, output unpadded_pos,
                  output pos_before, output pos_after, output out_quality,
                  output is_pad, output gap_length, output gap_closed,
                  output gap_overflow, output last_of_run, output last_of_seq,
                  input ready);
   modport sink(input valid, input padded_pos, input unpadded_pos,
                input pos_before, input pos_after, input out_quality,
                input is_pad, input gap_length, input gap_closed,
                input gap_overflow, input last_of_run, input last_of_seq,
                output ready);
endinterface

interface gaca_csr_if;
   logic                    valid;
   logic                    ready;
   gaca_pkg::csr_index_type index;
   logic [7:0]              data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### sv/gaca_ctrl.sv
// ============================================================================
// gaca_ctrl: sequencing controller
// Accepts a column beat when the output register can take its first result,
// then replays its other results one per cycle while the output is free.
// ============================================================================
module gaca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gaca_pkg::status_type status,
   output gaca_pkg::cmd_type    cmd
);

   gaca_pkg::state_type state_ff;
   gaca_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gaca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gaca_pkg::ST_IDLE: begin
            if (req_valid && status.out_free && status.new_more) begin
               state_in = gaca_pkg::ST_EMIT;
            end
         end
         gaca_pkg::ST_EMIT: begin
            if (status.out_free && status.saved_last) begin
               state_in = gaca_pkg::ST_IDLE;
            end
         end
         default: state_in = gaca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         gaca_pkg::ST_IDLE: begin
            req_ready    = status.out_free;
            cmd.accept   = req_valid && status.out_free;
            cmd.load_out = req_valid && status.out_free && status.new_has_result;
         end
         gaca_pkg::ST_EMIT: begin
            cmd.use_saved = 1'b1;
            cmd.load_out  = status.out_free;
            cmd.advance   = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
            cmd = '0;
         end
      endcase
   end

endmodule

### sv/gaca_datapath.sv
// ============================================================================
// gaca_datapath: sequence state, result generation and output register
// Classifies each column, updates the running counts, builds the plan of
// results that the column releases and forms one result beat at a time.
// ============================================================================
module gaca_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  gaca_pkg::cmd_type       cmd,
   output gaca_pkg::status_type    status,
   input  logic [7:0]              req_symbol,
   input  logic [7:0]              req_base_quality,
   input  logic                    req_seq_end,
   input  logic                    csr_write,
   input  gaca_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gaca_pkg::result_type    rsp_result,
   output logic                    rsp_last_of_run,
   output logic                    rsp_last_of_seq
);

   // held pads go out first, then the optional tail (a base or an overflow pad)
   typedef struct packed {
      logic [5:0]           held_count;
      logic [15:0]          held_first;
      logic [15:0]          held_before;
      logic [7:0]           held_quality;
      logic [5:0]           held_glen;
      logic                 held_closed;
      logic                 held_ovf;
      logic                 tail_valid;
      gaca_pkg::result_type tail;
      logic                 seq_end;
   } plan_type;

   function automatic logic [6:0] plan_total(plan_type p);
      return {1'b0, p.held_count} + {6'd0, p.tail_valid};
   endfunction

   function automatic gaca_pkg::result_type gen_result(plan_type p, logic [5:0] k);
      gaca_pkg::result_type r;
      if (k < p.held_count) begin
         r.padded_pos   = gaca_pkg::sat_add(p.held_first, {1'b0, k});
         r.unpadded_pos = 16'd0;
         r.pos_before   = p.held_before;
         r.pos_after    = {1'b0, p.held_before} + 17'd1;
         r.out_quality  = p.held_quality;
         r.is_pad       = 1'b1;
         r.gap_length   = p.held_glen;
         r.gap_closed   = p.held_closed;
         r.gap_overflow = p.held_ovf;
      end else begin
         r = p.tail;
      end
      return r;
   endfunction

   function automatic logic gen_last(plan_type p, logic [5:0] k);
      return ({1'b0, k} + 7'd1) == plan_total(p);
   endfunction

   logic [7:0]           pad_a_ff, pad_a_in;
   logic [7:0]           pad_b_ff, pad_b_in;
   logic [7:0]           prior_q_ff, prior_q_in;
   logic [5:0]           pend_ff, pend_in;
   logic [15:0]          base_cnt_ff, base_cnt_in;
   logic [15:0]          col_cnt_ff, col_cnt_in;
   logic [15:0]          run_first_ff, run_first_in;
   logic                 ovf_ff, ovf_in;
   plan_type             plan_ff, plan_new;
   logic [5:0]           idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   gaca_pkg::result_type out_result_ff;
   logic                 out_last_run_ff;
   logic                 out_last_seq_ff;

   logic                 is_pad;
   logic [15:0]          col_new;
   logic [15:0]          base_new;
   logic [7:0]           min_q;
   gaca_pkg::result_type ovf_pad_res;
   gaca_pkg::result_type base_res;
   plan_type             sel_plan;
   logic [5:0]           sel_idx;
   gaca_pkg::result_type sel_res;
   logic                 sel_last;

   assign is_pad   = (req_symbol == pad_a_ff) || (req_symbol == pad_b_ff);
   assign col_new  = gaca_pkg::sat_add(col_cnt_ff, 7'd1);
   assign base_new = gaca_pkg::sat_add(base_cnt_ff, 7'd1);
   assign min_q    = (prior_q_ff < req_base_quality) ? prior_q_ff : req_base_quality;

   always_comb begin
      ovf_pad_res.padded_pos   = col_new;
      ovf_pad_res.unpadded_pos = 16'd0;
      ovf_pad_res.pos_before   = base_cnt_ff;
      ovf_pad_res.pos_after    = {1'b0, base_cnt_ff} + 17'd1;
      ovf_pad_res.out_quality  = 8'd0;
      ovf_pad_res.is_pad       = 1'b1;
      ovf_pad_res.gap_length   = gaca_pkg::MaxGap;
      ovf_pad_res.gap_closed   = 1'b0;
      ovf_pad_res.gap_overflow = 1'b1;

      base_res.padded_pos   = col_new;
      base_res.unpadded_pos = base_new;
      base_res.pos_before   = base_new;
      base_res.pos_after    = {1'b0, base_new};
      base_res.out_quality  = req_base_quality;
      base_res.is_pad       = 1'b0;
      base_res.gap_length   = 6'd0;
      base_res.gap_closed   = 1'b0;
      base_res.gap_overflow = 1'b0;
   end

   // plan of the offered beat and the sequence state it leaves behind
   always_comb begin
      plan_new.held_count   = 6'd0;
      plan_new.held_first   = run_first_ff;
      plan_new.held_before  = base_cnt_ff;
      plan_new.held_quality = 8'd0;
      plan_new.held_glen    = 6'd0;
      plan_new.held_closed  = 1'b0;
      plan_new.held_ovf     = 1'b0;
      plan_new.tail_valid   = 1'b0;
      plan_new.tail         = ovf_pad_res;
      plan_new.seq_end      = req_seq_end;

      prior_q_in   = prior_q_ff;
      pend_in      = pend_ff;
      base_cnt_in  = base_cnt_ff;
      col_cnt_in   = col_new;
      run_first_in = run_first_ff;
      ovf_in       = ovf_ff;

      if (is_pad) begin
         if (ovf_ff) begin
            plan_new.tail_valid = 1'b1;
         end else if (pend_ff >= gaca_pkg::MaxGap) begin
            // flush the full run and everything after it as overflow
            plan_new.held_count = pend_ff;
            plan_new.held_glen  = gaca_pkg::MaxGap;
            plan_new.held_ovf   = 1'b1;
            plan_new.tail_valid = 1'b1;
            pend_in = 6'd0;
            ovf_in  = 1'b1;
         end else begin
            if (pend_ff == 6'd0) begin
               run_first_in = col_new;
            end
            pend_in = pend_ff + 6'd1;
            if (req_seq_end) begin
               plan_new.held_count = pend_in;
               plan_new.held_first = run_first_in;
               plan_new.held_glen  = pend_in;
            end
         end
      end else begin
         plan_new.held_count   = pend_ff;
         plan_new.held_quality = min_q;
         plan_new.held_glen    = pend_ff;
         plan_new.held_closed  = 1'b1;
         plan_new.tail_valid   = 1'b1;
         plan_new.tail         = base_res;
         pend_in     = 6'd0;
         base_cnt_in = base_new;
         prior_q_in  = req_base_quality;
         ovf_in      = 1'b0;
      end

      if (req_seq_end) begin
         prior_q_in   = 8'd0;
         pend_in      = 6'd0;
         base_cnt_in  = 16'd0;
         col_cnt_in   = 16'd0;
         run_first_in = 16'd0;
         ovf_in       = 1'b0;
      end
   end

   assign sel_plan = cmd.use_saved ? plan_ff : plan_new;
   assign sel_idx  = cmd.use_saved ? idx_ff : 6'd0;
   assign sel_res  = gen_result(sel_plan, sel_idx);
   assign sel_last = gen_last(sel_plan, sel_idx);

   always_comb begin
      status.out_free       = !out_valid_ff || rsp_ready;
      status.new_has_result = plan_total(plan_new) != 7'd0;
      status.new_more       = plan_total(plan_new) > 7'd1;
      status.saved_last     = gen_last(plan_ff, idx_ff);
   end

   always_comb begin
      pad_a_in = pad_a_ff;
      pad_b_in = pad_b_ff;
      if (csr_write) begin
         case (csr_index)
            gaca_pkg::CSR_PAD_A: pad_a_in = csr_data;
            gaca_pkg::CSR_PAD_B: pad_b_in = csr_data;
            default: begin
               pad_a_in = pad_a_ff;
               pad_b_in = pad_b_ff;
            end
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = 6'd1;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 6'd1;
      end
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_a_ff     <= gaca_pkg::PadSymbolAReset;
         pad_b_ff     <= gaca_pkg::PadSymbolBReset;
         prior_q_ff   <= 8'd0;
         pend_ff      <= 6'd0;
         base_cnt_ff  <= 16'd0;
         col_cnt_ff   <= 16'd0;
         run_first_ff <= 16'd0;
         ovf_ff       <= 1'b0;
         idx_ff       <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pad_a_ff     <= pad_a_in;
         pad_b_ff     <= pad_b_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         if (cmd.accept) begin
            prior_q_ff   <= prior_q_in;
            pend_ff      <= pend_in;
            base_cnt_ff  <= base_cnt_in;
            col_cnt_ff   <= col_cnt_in;
            run_first_ff <= run_first_in;
            ovf_ff       <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         plan_ff <= plan_new;
      end
      if (cmd.load_out) begin
         out_result_ff   <= sel_res;
         out_last_run_ff <= sel_last;
         out_last_seq_ff <= sel_last && sel_plan.seq_end;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = out_result_ff;
   assign rsp_last_of_run = out_last_run_ff;
   assign rsp_last_of_seq = out_last_seq_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= gaca_pkg::MaxGap) && !(ovf_ff && (pend_ff != 6'd0)))
      else $error("held pad count out of range or held during overflow");

   a_seq_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_seq_end) |=>
         (col_cnt_ff == 16'd0) && (base_cnt_ff == 16'd0) && (pend_ff == 6'd0) && !ovf_ff)
      else $error("sequence state not cleared after end of sequence");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a beat that is still waiting");

   a_accept_replay: assert property (@(posedge clock) disable iff (reset)
      cmd.use_saved |-> !cmd.accept)
      else $error("column accepted while replaying a held run");

endmodule

### sv/gapped_alignment_column_annotator_unit.sv
// ============================================================================
// gapped_alignment_column_annotator_unit: padded alignment column annotator
// Top level: controller, datapath and channel wiring.
// ============================================================================
// Takes one padded-alignment column per beat and returns an annotated result
// beat for every column, in order. Pad columns (symbol equal to either pad
// register) are held until the next base or the end of the sequence; a column
// beat then releases the held pads followed by its own result. Results go out
// one per cycle through the single output register while it is free, and a
// pad that is only held yields none, so a stream of bases runs at one column
// per cycle while the output is free. A new column is taken only once the
// previous column's results have all entered the output register.
// Past 63 pads, a run's held pads and each later pad go out as overflow pads.
module gapped_alignment_column_annotator_unit (
   input logic        clock,
   input logic        reset,
   gaca_req_if.sink   req_ch,
   gaca_rsp_if.source rsp_ch,
   gaca_csr_if.sink   csr_ch
);

   gaca_pkg::cmd_type    cmd;
   gaca_pkg::status_type status;
   gaca_pkg::result_type result;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 last_of_run;
   logic                 last_of_seq;

   gaca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gaca_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_symbol       (req_ch.symbol),
      .req_base_quality (req_ch.base_quality),
      .req_seq_end      (req_ch.seq_end),
      .csr_write        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_result       (result),
      .rsp_last_of_run  (last_of_run),
      .rsp_last_of_seq  (last_of_seq)
   );

   // register writes always complete in one beat
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.padded_pos   = result.padded_pos;
   assign rsp_ch.unpadded_pos = result.unpadded_pos;
   assign rsp_ch.pos_before   = result.pos_before;
   assign rsp_ch.pos_after    = result.pos_after;
   assign rsp_ch.out_quality  = result.out_quality;
   assign rsp_ch.is_pad       = result.is_pad;
   assign rsp_ch.gap_length   = result.gap_length;
   assign rsp_ch.gap_closed   = result.gap_closed;
   assign rsp_ch.gap_overflow = result.gap_overflow;
   assign rsp_ch.last_of_run  = last_of_run;
   assign rsp_ch.last_of_seq  = last_of_seq;

endmodule
